[hw/rtl/smtde_pkg.sv]
// ----------------------------------------------------------------------------
// smtde_pkg
// Shared widths, codes, types and helper functions of the two-axis sliding
// mode controller with time-delay estimation.
// ----------------------------------------------------------------------------
package smtde_pkg;

  localparam int AXES  = 2;
  localparam int DW    = 16;            // Q8.8 inputs and gain entries
  localparam int CW    = 32;            // Q16.16 control
  localparam int FRAC  = 8;
  localparam int AW    = 36;            // surface / correction accumulator
  localparam int LOW   = 18;            // low split of the correction word
  localparam int MBW   = LOW + 1;       // multiplier b operand
  localparam int PW    = DW + MBW;      // product width
  localparam int DAW   = 54;            // gain product accumulator
  localparam int SW    = DAW - FRAC + 1;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 64;
  localparam int GW     = 32;

  localparam logic signed [DAW-1:0] ROUND_HALF = DAW'(1) <<< (FRAC - 1);

  typedef enum logic [CFG_IW-1:0] {
    REG_LAMBDA = 2'd0,
    REG_K      = 2'd1,
    REG_GINV   = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_S0A, ST_S0B, ST_S1A, ST_S1B, ST_S1SIGN,
    ST_V0A, ST_V0B, ST_G0LO, ST_G0HI, ST_G0ADD,
    ST_V1A, ST_V1B, ST_G1LO, ST_G1HI, ST_G1ADD,
    ST_DONE
  } step_t;

  localparam logic signed [1:0] SG_POS  = 2'sb01;
  localparam logic signed [1:0] SG_NEG  = 2'sb11;
  localparam logic signed [1:0] SG_ZERO = 2'sb00;

  typedef struct packed {
    logic  en;
    step_t step;
  } ctrl_t;

  typedef struct packed {
    logic signed [DW-1:0] prev_accel_0;
    logic signed [DW-1:0] prev_accel_1;
    logic signed [DW-1:0] desired_accel_0;
    logic signed [DW-1:0] desired_accel_1;
    logic signed [DW-1:0] pos_err_0;
    logic signed [DW-1:0] pos_err_1;
    logic signed [DW-1:0] vel_err_0;
    logic signed [DW-1:0] vel_err_1;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] control_0;
    logic signed [CW-1:0] control_1;
    logic                 reach_ok;
  } result_t;

  function automatic logic signed [DW-1:0] entry(input logic [CFG_DW-1:0] w,
                                                 input int unsigned idx);
    return w[idx*DW +: DW];
  endfunction

  function automatic logic signed [1:0] sgn(input logic signed [AW-1:0] v);
    if (v == '0) return SG_ZERO;
    if (v[AW-1]) return SG_NEG;
    return SG_POS;
  endfunction

  function automatic logic signed [DW:0] kterm(input logic signed [DW-1:0] k,
                                               input logic signed [1:0] s);
    logic signed [DW:0] kx;
    kx = (DW+1)'(k);
    if (s == SG_POS) return kx;
    if (s == SG_NEG) return -kx;
    return '0;
  endfunction

  function automatic logic signed [1:0] sprod(input logic signed [1:0] a,
                                              input logic signed [1:0] b);
    if (a == SG_ZERO || b == SG_ZERO) return SG_ZERO;
    if (a == b) return SG_POS;
    return SG_NEG;
  endfunction

endpackage

[hw/rtl/smtde_if.sv]
// ----------------------------------------------------------------------------
// smtde_in_if / smtde_out_if
// Valid/ready channels that carry one input word and one result word.
// ----------------------------------------------------------------------------
interface smtde_in_if;
  logic valid;
  logic ready;
  logic signed [smtde_pkg::DW-1:0] prev_accel_0;
  logic signed [smtde_pkg::DW-1:0] prev_accel_1;
  logic signed [smtde_pkg::DW-1:0] desired_accel_0;
  logic signed [smtde_pkg::DW-1:0] desired_accel_1;
  logic signed [smtde_pkg::DW-1:0] pos_err_0;
  logic signed [smtde_pkg::DW-1:0] pos_err_1;
  logic signed [smtde_pkg::DW-1:0] vel_err_0;
  logic signed [smtde_pkg::DW-1:0] vel_err_1;

  modport source (output valid, prev_accel_0, prev_accel_1, desired_accel_0,
                  desired_accel_1, pos_err_0, pos_err_1, vel_err_0, vel_err_1,
                  input ready);
  modport sink (input valid, prev_accel_0, prev_accel_1, desired_accel_0,
                desired_accel_1, pos_err_0, pos_err_1, vel_err_0, vel_err_1,
                output ready);
endinterface

interface smtde_out_if;
  logic valid;
  logic ready;
  logic signed [smtde_pkg::CW-1:0] control_0;
  logic signed [smtde_pkg::CW-1:0] control_1;
  logic                            reach_ok;

  modport source (output valid, control_0, control_1, reach_ok, input ready);
  modport sink (input valid, control_0, control_1, reach_ok, output ready);
endinterface

[hw/rtl/smtde_mul.sv]
// ----------------------------------------------------------------------------
// smtde_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module smtde_mul (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [smtde_pkg::DW-1:0]   a,
  input  logic signed [smtde_pkg::MBW-1:0]  b,
  output logic signed [smtde_pkg::PW-1:0]   prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= smtde_pkg::PW'(a) * smtde_pkg::PW'(b);
    end
  end

endmodule

[hw/rtl/smtde_dp.sv]
// ----------------------------------------------------------------------------
// smtde_dp
// Datapath: operand selection for the shared multiplier, surface and
// correction accumulators, rounding, saturation and the control state.
// ----------------------------------------------------------------------------
module smtde_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  smtde_pkg::ctrl_t                  ctrl,
  input  smtde_pkg::in_word_t               word,
  input  logic [smtde_pkg::CFG_DW-1:0]      lambda_matrix,
  input  logic [smtde_pkg::CFG_DW-1:0]      k_matrix,
  input  logic [smtde_pkg::GW-1:0]          ginv_diag,
  output smtde_pkg::result_t                result
);

  localparam int AW  = smtde_pkg::AW;
  localparam int DAW = smtde_pkg::DAW;
  localparam int SW  = smtde_pkg::SW;
  localparam int CW  = smtde_pkg::CW;
  localparam int DW  = smtde_pkg::DW;
  localparam int MBW = smtde_pkg::MBW;
  localparam int LOW = smtde_pkg::LOW;
  localparam int AX  = smtde_pkg::AXES;

  logic signed [DW-1:0]  pe  [AX];
  logic signed [DW-1:0]  ve  [AX];
  logic signed [DW-1:0]  des [AX];
  logic signed [DW-1:0]  prv [AX];
  logic signed [1:0]     sg  [AX];
  logic signed [CW-1:0]  ctl [AX];

  logic signed [AW-1:0]         acc;
  logic signed [AW-1:0]         acc_sum;
  logic signed [DAW-1:0]        dacc;
  logic signed [DW-1:0]         mul_a;
  logic signed [MBW-1:0]        mul_b;
  logic signed [smtde_pkg::PW-1:0] prod;
  logic signed [MBW-1:0]        v_lo;
  logic signed [MBW-1:0]        v_hi;
  logic [smtde_pkg::CFG_DW-1:0] ginv_w;
  logic                         ax_v;
  logic                         ax_s;
  logic signed [DW+1:0]         base_d;
  logic signed [AW-1:0]         base_v;
  logic signed [SW-1:0]         sum_s;
  logic signed [CW-1:0]         sat_v;
  logic signed [DW+2:0]         rsum;

  assign pe[0]  = word.pos_err_0;
  assign pe[1]  = word.pos_err_1;
  assign ve[0]  = word.vel_err_0;
  assign ve[1]  = word.vel_err_1;
  assign des[0] = word.desired_accel_0;
  assign des[1] = word.desired_accel_1;
  assign prv[0] = word.prev_accel_0;
  assign prv[1] = word.prev_accel_1;

  assign ginv_w  = {{(smtde_pkg::CFG_DW - smtde_pkg::GW){1'b0}}, ginv_diag};
  assign acc_sum = acc + AW'(prod);
  assign v_lo    = $signed({1'b0, acc[LOW-1:0]});
  assign v_hi    = MBW'($signed(acc[AW-1:LOW]));

  always_comb begin
    unique case (ctrl.step)
      smtde_pkg::ST_S0A: begin
        mul_a = smtde_pkg::entry(lambda_matrix, 0);
        mul_b = MBW'(pe[0]);
      end
      smtde_pkg::ST_S0B: begin
        mul_a = smtde_pkg::entry(lambda_matrix, 1);
        mul_b = MBW'(pe[1]);
      end
      smtde_pkg::ST_S1A: begin
        mul_a = smtde_pkg::entry(lambda_matrix, 2);
        mul_b = MBW'(pe[0]);
      end
      smtde_pkg::ST_S1B: begin
        mul_a = smtde_pkg::entry(lambda_matrix, 3);
        mul_b = MBW'(pe[1]);
      end
      smtde_pkg::ST_S1SIGN: begin
        mul_a = smtde_pkg::entry(lambda_matrix, 0);
        mul_b = MBW'(ve[0]);
      end
      smtde_pkg::ST_V0A: begin
        mul_a = smtde_pkg::entry(lambda_matrix, 1);
        mul_b = MBW'(ve[1]);
      end
      smtde_pkg::ST_G0LO: begin
        mul_a = smtde_pkg::entry(ginv_w, 0);
        mul_b = v_lo;
      end
      smtde_pkg::ST_G0HI: begin
        mul_a = smtde_pkg::entry(ginv_w, 0);
        mul_b = v_hi;
      end
      smtde_pkg::ST_G0ADD: begin
        mul_a = smtde_pkg::entry(lambda_matrix, 2);
        mul_b = MBW'(ve[0]);
      end
      smtde_pkg::ST_V1A: begin
        mul_a = smtde_pkg::entry(lambda_matrix, 3);
        mul_b = MBW'(ve[1]);
      end
      smtde_pkg::ST_G1LO: begin
        mul_a = smtde_pkg::entry(ginv_w, 1);
        mul_b = v_lo;
      end
      smtde_pkg::ST_G1HI: begin
        mul_a = smtde_pkg::entry(ginv_w, 1);
        mul_b = v_hi;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  smtde_mul u_mul (
    .clk  (clk),
    .en   (ctrl.en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // base of the correction: (desired - prev - K*sign(S)) in Q20.16
  assign ax_v = (ctrl.step == smtde_pkg::ST_V1A);
  assign ax_s = !ax_v;

  always_comb begin
    base_d = (DW+2)'(des[ax_v]) - (DW+2)'(prv[ax_v])
           - (DW+2)'(smtde_pkg::kterm(smtde_pkg::entry(k_matrix, int'(ax_v) * AX), sg[0]))
           - (DW+2)'(smtde_pkg::kterm(smtde_pkg::entry(k_matrix, int'(ax_v) * AX + 1),
                                      sg[1]));
    base_v = AW'(base_d) <<< smtde_pkg::FRAC;
  end

  // round to Q16.16, add, saturate
  always_comb begin
    sum_s = SW'(ctl[ax_s]) + SW'(dacc >>> smtde_pkg::FRAC);
    if (sum_s[SW-1:CW-1] == '0 || sum_s[SW-1:CW-1] == '1) begin
      sat_v = sum_s[CW-1:0];
    end else if (sum_s[SW-1]) begin
      sat_v = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat_v = {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_comb begin
    rsum = '0;
    for (int i = 0; i < AX; i++) begin
      for (int j = 0; j < AX; j++) begin
        rsum = rsum + (DW+3)'(smtde_pkg::kterm(smtde_pkg::entry(k_matrix, i * AX + j),
                                               smtde_pkg::sprod(sg[i], sg[j])));
      end
    end
  end

  assign result.control_0 = ctl[0];
  assign result.control_1 = sat_v;
  assign result.reach_ok  = !rsum[DW+2] && (rsum != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AX; i++) begin
        ctl[i] <= '0;
      end
    end else if (ctrl.en) begin
      unique case (ctrl.step)
        smtde_pkg::ST_S0A:    acc <= AW'(ve[0]) <<< smtde_pkg::FRAC;
        smtde_pkg::ST_S0B:    acc <= acc_sum;
        smtde_pkg::ST_S1A: begin
          sg[0] <= smtde_pkg::sgn(acc_sum);
          acc   <= AW'(ve[1]) <<< smtde_pkg::FRAC;
        end
        smtde_pkg::ST_S1B:    acc <= acc_sum;
        smtde_pkg::ST_S1SIGN: sg[1] <= smtde_pkg::sgn(acc_sum);
        smtde_pkg::ST_V0A:    acc <= base_v - AW'(prod);
        smtde_pkg::ST_V0B:    acc <= acc - AW'(prod);
        smtde_pkg::ST_G0HI:   dacc <= DAW'(prod) + smtde_pkg::ROUND_HALF;
        smtde_pkg::ST_G0ADD:  dacc <= dacc + (DAW'(prod) <<< LOW);
        smtde_pkg::ST_V1A: begin
          ctl[0] <= sat_v;
          acc    <= base_v - AW'(prod);
        end
        smtde_pkg::ST_V1B:    acc <= acc - AW'(prod);
        smtde_pkg::ST_G1HI:   dacc <= DAW'(prod) + smtde_pkg::ROUND_HALF;
        smtde_pkg::ST_G1ADD:  dacc <= dacc + (DAW'(prod) <<< LOW);
        smtde_pkg::ST_DONE:   ctl[1] <= sat_v;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/sliding_mode_tde_control_step.sv]
// ----------------------------------------------------------------------------
// sliding_mode_tde_control_step
// Two-axis sliding mode controller with time-delay estimation: surface sign,
// switching term, inverse-gain correction and a saturating Q16.16 control.
//
//   port        dir   handshake      word
//   in_ch       sink  valid/ready    accel, desired accel, pos/vel errors
//   out_ch      src   valid/ready    control_0, control_1, reach_ok
//   cfg_*       in    cfg_we only    lambda, K, inverse gain registers
//
// After acceptance a word runs through every step of the sequencer
// driving the single shared 16x19 multiplier; in_ch.ready is low meanwhile,
// so no new word is taken until the one before it has finished.
// A finished result sits in the output register, so the next word is taken
// while it waits; the sequencer holds on its last step only if that register
// is still full. Reset clears the registers and the control to zero.
// ----------------------------------------------------------------------------
module sliding_mode_tde_control_step (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [smtde_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [smtde_pkg::CFG_DW-1:0]      cfg_data,
  smtde_in_if.sink                          in_ch,
  smtde_out_if.source                       out_ch
);

  logic [smtde_pkg::CFG_DW-1:0] lambda_matrix;
  logic [smtde_pkg::CFG_DW-1:0] k_matrix;
  logic [smtde_pkg::GW-1:0]     ginv_diag;
  logic                         busy;
  smtde_pkg::step_t             step;
  smtde_pkg::in_word_t          word;
  smtde_pkg::ctrl_t             ctrl;
  smtde_pkg::result_t           result;
  logic                         out_free;
  logic                         accept;

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && !busy;
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign ctrl.step   = step;
  assign ctrl.en     = busy && (step != smtde_pkg::ST_DONE || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda_matrix <= '0;
      k_matrix      <= '0;
      ginv_diag     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smtde_pkg::REG_LAMBDA: lambda_matrix <= cfg_data;
        smtde_pkg::REG_K:      k_matrix      <= cfg_data;
        smtde_pkg::REG_GINV:   ginv_diag     <= cfg_data[smtde_pkg::GW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      step         <= smtde_pkg::ST_S0A;
      out_ch.valid <= 1'b0;
    end else begin
      if (accept) begin
        busy                 <= 1'b1;
        step                 <= smtde_pkg::ST_S0A;
        word.prev_accel_0    <= in_ch.prev_accel_0;
        word.prev_accel_1    <= in_ch.prev_accel_1;
        word.desired_accel_0 <= in_ch.desired_accel_0;
        word.desired_accel_1 <= in_ch.desired_accel_1;
        word.pos_err_0       <= in_ch.pos_err_0;
        word.pos_err_1       <= in_ch.pos_err_1;
        word.vel_err_0       <= in_ch.vel_err_0;
        word.vel_err_1       <= in_ch.vel_err_1;
      end else if (ctrl.en) begin
        if (step == smtde_pkg::ST_DONE) begin
          busy <= 1'b0;
        end else begin
          step <= smtde_pkg::step_t'(step + 1'b1);
        end
      end
      if (ctrl.en && step == smtde_pkg::ST_DONE) begin
        out_ch.valid     <= 1'b1;
        out_ch.control_0 <= result.control_0;
        out_ch.control_1 <= result.control_1;
        out_ch.reach_ok  <= result.reach_ok;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  smtde_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .word          (word),
    .lambda_matrix (lambda_matrix),
    .k_matrix      (k_matrix),
    .ginv_diag     (ginv_diag),
    .result        (result)
  );

endmodule

[dv/tb_sliding_mode_tde_control_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_mode_tde_control_step
// Drives the two-axis sliding mode controller with random and corner input
// words under several gain settings, predicts each control and reach flag
// from its own fixed-point model and compares every result word in order.
// ----------------------------------------------------------------------------
module tb_sliding_mode_tde_control_step;

  localparam logic [smtde_pkg::CFG_IW-1:0] REG_NONE = 2'd3;
  localparam int WATCHDOG = 4000;

  class tde_control_tracker;
    logic [63:0]         lambda_w;
    logic [63:0]         k_w;
    logic [31:0]         ginv_w;
    int                  acc[2];
    smtde_pkg::result_t  due_controls[$];
    int                  errors;

    function new();
      lambda_w = '0;
      k_w      = '0;
      ginv_w   = '0;
      acc[0]   = 0;
      acc[1]   = 0;
      errors   = 0;
    endfunction

    function void set_reg(logic [smtde_pkg::CFG_IW-1:0] idx, logic [63:0] data);
      case (idx)
        smtde_pkg::REG_LAMBDA: lambda_w = data;
        smtde_pkg::REG_K:      k_w = data;
        smtde_pkg::REG_GINV:   ginv_w = data[31:0];
        default: ;
      endcase
    endfunction

    function longint gain_at(logic [63:0] w, int idx);
      return longint'($signed(w[idx*16 +: 16]));
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void take_sample(smtde_pkg::in_word_t w);
      longint             prev[2], des[2], pe[2], ve[2], sg[2];
      longint             s, v, d, sum;
      smtde_pkg::result_t r;
      prev[0] = $signed(w.prev_accel_0);
      prev[1] = $signed(w.prev_accel_1);
      des[0]  = $signed(w.desired_accel_0);
      des[1]  = $signed(w.desired_accel_1);
      pe[0]   = $signed(w.pos_err_0);
      pe[1]   = $signed(w.pos_err_1);
      ve[0]   = $signed(w.vel_err_0);
      ve[1]   = $signed(w.vel_err_1);
      for (int i = 0; i < 2; i++) begin
        s = ve[i] * 256;
        for (int j = 0; j < 2; j++) s += gain_at(lambda_w, i*2+j) * pe[j];
        sg[i] = (s > 0) ? 1 : ((s < 0) ? -1 : 0);
      end
      d = 0;
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++) d -= sg[i] * gain_at(k_w, i*2+j) * sg[j];
      for (int i = 0; i < 2; i++) begin
        v = (des[i] - prev[i]) * 256;
        for (int j = 0; j < 2; j++) begin
          v -= gain_at(lambda_w, i*2+j) * ve[j];
          v -= gain_at(k_w, i*2+j) * sg[j] * 256;
        end
        sum = longint'(acc[i]) + ((gain_at({32'b0, ginv_w}, i) * v + 128) >>> 8);
        if (sum > 64'sd2147483647) acc[i] = 32'sh7FFFFFFF;
        else if (sum < -64'sd2147483648) acc[i] = 32'sh80000000;
        else acc[i] = int'(sum);
      end
      r.control_0 = acc[0];
      r.control_1 = acc[1];
      r.reach_ok  = (d < 0);
      due_controls.push_back(r);
    endfunction

    function void compare_control(smtde_pkg::result_t got);
      smtde_pkg::result_t want;
      if (due_controls.size() == 0) begin
        flag($sformatf("unexpected word: control_0=%0d control_1=%0d reach_ok=%0b",
                       got.control_0, got.control_1, got.reach_ok));
        return;
      end
      want = due_controls.pop_front();
      if (got.control_0 !== want.control_0 || got.control_1 !== want.control_1 ||
          got.reach_ok !== want.reach_ok)
        flag($sformatf("mismatch: expected %0d %0d %0b, actual %0d %0d %0b",
                       want.control_0, want.control_1, want.reach_ok,
                       got.control_0, got.control_1, got.reach_ok));
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [smtde_pkg::CFG_IW-1:0]    cfg_index;
  logic [smtde_pkg::CFG_DW-1:0]    cfg_data;
  bit                              steady = 1'b0;
  int                              idle_cycles = 0;
  tde_control_tracker              tracker = new();

  smtde_in_if  in_ch();
  smtde_out_if out_ch();

  sliding_mode_tde_control_step dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] rand_field();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 16'($urandom);
    if (pick < 85) return 16'($urandom_range(0, 2048) - 1024);
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [63:0] rand_gains(int span);
    logic [63:0] g;
    for (int i = 0; i < 4; i++)
      g[i*16 +: 16] = (span == 0) ? 16'($urandom)
                                  : 16'($urandom_range(0, 2*span) - span);
    return g;
  endfunction

  task automatic cfg_write(logic [smtde_pkg::CFG_IW-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tracker.set_reg(idx, data);
  endtask

  task automatic send_word(smtde_pkg::in_word_t w);
    if (!steady && $urandom_range(0, 99) < 26)
      repeat ($urandom_range(1, 24)) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    @(negedge clk);
    in_ch.valid           <= 1'b1;
    in_ch.prev_accel_0    <= w.prev_accel_0;
    in_ch.prev_accel_1    <= w.prev_accel_1;
    in_ch.desired_accel_0 <= w.desired_accel_0;
    in_ch.desired_accel_1 <= w.desired_accel_1;
    in_ch.pos_err_0       <= w.pos_err_0;
    in_ch.pos_err_1       <= w.pos_err_1;
    in_ch.vel_err_0       <= w.vel_err_0;
    in_ch.vel_err_1       <= w.vel_err_1;
    do @(posedge clk); while (!in_ch.ready);
    tracker.take_sample(w);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.due_controls.size() != 0) @(posedge clk);
  endtask

  // sink side: random stalls, a rare long one to back up the output register
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!steady && $urandom_range(0, 99) < 2) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(16, 40)) @(negedge clk);
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        tracker.compare_control('{control_0: out_ch.control_0,
                                  control_1: out_ch.control_1,
                                  reach_ok:  out_ch.reach_ok});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb_sliding_mode_tde_control_step: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.prev_accel_0    = '0;
    in_ch.prev_accel_1    = '0;
    in_ch.desired_accel_0 = '0;
    in_ch.desired_accel_1 = '0;
    in_ch.pos_err_0       = '0;
    in_ch.pos_err_1       = '0;
    in_ch.vel_err_0       = '0;
    in_ch.vel_err_1       = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero gains: control holds at zero, no reach
    send_word({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_word({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_word({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    drain();

    // unit lambda, ginv; K of 0.5: zero, positive, negative, mixed surfaces
    cfg_write(smtde_pkg::REG_LAMBDA, 64'h0100_0000_0000_0100);
    cfg_write(smtde_pkg::REG_K,      64'h0080_0000_0000_0080);
    cfg_write(smtde_pkg::REG_GINV,   64'h0000_0000_0100_0100);
    send_word({16'h0000, 16'h0000, 16'h0100, 16'hFF00, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_word({16'h0010, 16'hFFF0, 16'h0040, 16'h0020, 16'h0100, 16'h0100, 16'h0040, 16'h0040});
    send_word({16'h0010, 16'hFFF0, 16'h0040, 16'h0020, 16'hFF00, 16'hFF00, 16'hFFC0, 16'hFFC0});
    send_word({16'h0000, 16'h0000, 16'h0080, 16'h0080, 16'h0100, 16'hFF00, 16'h0040, 16'hFFC0});
    send_word({16'h0020, 16'h0000, 16'h0000, 16'h0020, 16'h0000, 16'h0200, 16'h0000, 16'h0010});
    send_word({16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_word({16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    drain();

    // extreme gains: drive both controls into saturation and back
    cfg_write(smtde_pkg::REG_LAMBDA, 64'h7FFF_7FFF_7FFF_7FFF);
    cfg_write(smtde_pkg::REG_K,      64'h8000_8000_8000_8000);
    cfg_write(smtde_pkg::REG_GINV,   64'hFFFF_FFFF_7FFF_7FFF);
    send_word({16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000});
    send_word({16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000});
    send_word({16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_word({16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
    send_word({16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
    drain();

    cfg_write(REG_NONE,              {$urandom, $urandom});
    cfg_write(smtde_pkg::REG_LAMBDA, 64'h8000_8000_8000_8000);
    cfg_write(smtde_pkg::REG_K,      64'h7FFF_7FFF_7FFF_7FFF);
    cfg_write(smtde_pkg::REG_GINV,   64'h0000_0000_8000_8000);
    send_word({16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    send_word({16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    send_word({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001});
    send_word({16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000});
    send_word({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    drain();

    for (int p = 0; p < 8; p++) begin
      cfg_write(smtde_pkg::REG_LAMBDA, rand_gains((p == 3 || p == 6) ? 0 : 384));
      cfg_write(smtde_pkg::REG_K,      rand_gains((p == 3 || p == 6) ? 0 : 384));
      cfg_write(smtde_pkg::REG_GINV,   rand_gains((p == 3 || p == 6) ? 0 : 160));
      if (p % 3 == 1) cfg_write(REG_NONE, {$urandom, $urandom});
      steady = (p == 5);
      repeat (220)
        send_word({rand_field(), rand_field(), rand_field(), rand_field(),
                   rand_field(), rand_field(), rand_field(), rand_field()});
      drain();
    end
    steady = 1'b0;

    repeat (40) @(posedge clk);
    if (tracker.due_controls.size() != 0)
      tracker.flag($sformatf("%0d results never arrived", tracker.due_controls.size()));
    if (tracker.errors == 0) $display("tb_sliding_mode_tde_control_step: PASS");
    else $display("tb_sliding_mode_tde_control_step: FAIL");
    $finish;
  end

endmodule
